[src/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/fisqrt_pkg.sv]
// ----------------------------------------------------------------------------
// fisqrt_pkg
// Constants, types and binary32 helper functions for the inverse square root.
// ----------------------------------------------------------------------------
package fisqrt_pkg;

	localparam logic [31:0] MAGIC_GUESS = 32'h5f3759df;
	localparam logic [31:0] QNAN_BITS = 32'h7FC00000;
	localparam logic [31:0] ONE_HALF = 32'h3F000000;
	localparam logic [31:0] THREE_HALVES = 32'h3FC00000;

	// Register stages from operand to result
	localparam int PIPE_DEPTH = 10;

	typedef logic [31:0] f32_t;

	// Unrounded binary32 result: special flags plus a magnitude before rounding.
	typedef struct packed {
		logic        sign;
		logic        is_nan;
		logic        is_inf;
		logic        is_zero;
		logic signed [10:0] exp;   // biased exponent of prod bit 47
		logic [47:0] prod;
	} mul_raw_t;

	// Split a float into biased-like exponent and significand with hidden bit
	function automatic logic [23:0] sig_of(input f32_t a);
		sig_of = {(a[30:23] != 8'd0), a[22:0]};
	endfunction

	function automatic logic signed [10:0] exp_of(input f32_t a);
		exp_of = (a[30:23] == 8'd0) ? 11'sd1 : {3'b000, a[30:23]};
	endfunction

	// Round a magnitude to binary32 with nearest-even.
	// mag is normalized with its leading one at bit 47 (or zero); e is the biased
	// exponent of bit 47 (value = mag/2^47 * 2^(e-127)).
	function automatic f32_t round_pack(input logic sgn, input logic signed [10:0] e,
			input logic [47:0] mag);
		logic [47:0] m;
		logic [5:0]  sh;
		logic        sticky;
		logic [24:0] r;
		logic [23:0] kept;
		logic        g;
		logic        st;
		logic signed [10:0] ee;
		logic [8:0]  ef;
		f32_t        o;
		m = mag;
		ee = e;
		sticky = 1'b0;
		if (mag == 48'd0) begin
			o = {sgn, 31'd0};
		end else begin
			if (e < 11'sd1) begin
				// subnormal: shift right by 1-e
				if ((11'sd1 - e) > 11'sd47) begin
					sh = 6'd48;
				end else begin
					sh = 6'((11'sd1 - e));
				end
				sticky = ((mag & ~(48'hFFFFFFFFFFFF << sh)) != 48'd0) || (sh == 6'd48);
				m = (sh == 6'd48) ? 48'd0 : (mag >> sh);
				ee = 11'sd0;
			end
			kept = m[47:24];
			g = m[23];
			st = (m[22:0] != 23'd0) || sticky;
			r = {1'b0, kept} + {24'd0, (g && (st || kept[0]))};
			ef = 9'(ee);
			if (ee == 11'sd0) begin
				// subnormal result, may round up into the normal range
				o = {sgn, (r[23] ? 8'd1 : 8'd0), r[22:0]};
			end else if (r[24]) begin
				ef = ef + 9'd1;
				o = {sgn, ef[7:0], r[23:1]};
				if (ef >= 9'd255) o = {sgn, 8'hFF, 23'd0};
			end else begin
				o = {sgn, ef[7:0], r[22:0]};
				if (ef >= 9'd255) o = {sgn, 8'hFF, 23'd0};
			end
			if (ee > 11'sd254) o = {sgn, 8'hFF, 23'd0};
		end
		round_pack = o;
	endfunction

	// Normalize: count leading zeros of a 48-bit value
	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		n = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (v[i]) n = 6'(47 - i);
		end
		lzc48 = n;
	endfunction

	// Multiply front end: classify and form the raw product
	function automatic mul_raw_t mul_front(input f32_t a, input f32_t b);
		mul_raw_t o;
		logic a_nan, b_nan, a_inf, b_inf, a_z, b_z;
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		a_z = (a[30:0] == 31'd0);
		b_z = (b[30:0] == 31'd0);
		o.sign = a[31] ^ b[31];
		o.is_nan = a_nan || b_nan || (a_inf && b_z) || (b_inf && a_z);
		o.is_inf = (a_inf || b_inf);
		o.is_zero = a_z || b_z;
		o.prod = sig_of(a) * sig_of(b);
		// prod bit 46 weighs 2^(ea+eb-254); bit 47 one above
		o.exp = exp_of(a) + exp_of(b) - 11'sd126;
		mul_front = o;
	endfunction

	// Back end shared by multiply and subtract: normalize and round
	function automatic f32_t mul_back(input mul_raw_t p);
		logic [5:0] lz;
		f32_t o;
		lz = lzc48(p.prod);
		if (p.is_nan) o = QNAN_BITS;
		else if (p.is_inf) o = {p.sign, 8'hFF, 23'd0};
		else if (p.is_zero) o = {p.sign, 31'd0};
		else o = round_pack(p.sign, p.exp - 11'(lz), p.prod << lz);
		mul_back = o;
	endfunction

	// 1.5 - t front end: align to the larger exponent, jam shifted-out bits
	// into the lsb, then add or subtract magnitudes. Bit 50 of the window
	// carries the leading one of the larger operand.
	function automatic mul_raw_t sub_front(input f32_t t);
		mul_raw_t o;
		logic [23:0] ts;
		logic signed [10:0] te;
		logic signed [10:0] eb;
		logic [10:0] d;
		logic        t_small;
		logic [51:0] a;
		logic [51:0] b;
		logic [51:0] sml;
		logic [51:0] lost;
		logic [51:0] av;
		logic [51:0] bv;
		logic [51:0] sum;
		ts = sig_of(t);
		te = exp_of(t);
		a = {1'b0, 24'hC00000, 27'd0};
		b = {1'b0, ts, 27'd0};
		t_small = (te <= 11'sd127);
		eb = t_small ? 11'sd127 : te;
		d = t_small ? 11'(11'sd127 - te) : 11'(te - 11'sd127);
		sml = t_small ? b : a;
		if (d >= 11'd52) begin
			sml = (sml != 52'd0) ? 52'd1 : 52'd0;
		end else begin
			lost = sml & ~({52{1'b1}} << d);
			sml = (sml >> d) | {51'd0, (lost != 52'd0)};
		end
		av = t_small ? a : sml;
		bv = t_small ? sml : b;
		o.is_nan = (t[30:23] == 8'hFF) && (t[22:0] != 23'd0);
		o.is_inf = (t[30:23] == 8'hFF) && (t[22:0] == 23'd0);
		if (t[31]) begin
			sum = av + bv;
			o.sign = 1'b0;
		end else if (av >= bv) begin
			sum = av - bv;
			o.sign = 1'b0;
		end else begin
			sum = bv - av;
			o.sign = 1'b1;
		end
		if (o.is_inf) o.sign = ~t[31];
		o.is_zero = (sum == 52'd0);
		o.prod = sum[51:4] | {47'd0, (sum[3:0] != 4'd0)};
		o.exp = eb + 11'sd1;
		sub_front = o;
	endfunction

endpackage

[src/fisqrt_if.sv]
// ----------------------------------------------------------------------------
// fisqrt_if
// Valid/ready channel carrying one 32-bit binary32 pattern.
// ----------------------------------------------------------------------------
interface fisqrt_if;
	logic        valid;
	logic        ready;
	logic [31:0] bits;
	modport source (output valid, output bits, input ready);
	modport sink (input valid, input bits, output ready);
endinterface

[src/fast_inverse_sqrt_float_unit.sv]
// ----------------------------------------------------------------------------
// fast_inverse_sqrt_float_unit
// Pipelined magic-constant guess and one Newton step for 1/sqrt(x), binary32.
// ----------------------------------------------------------------------------
// channel   dir   payload
// in_ch     in    operand_bits (bits, 32)
// out_ch    out   result_bits  (bits, 32)
// One item enters per cycle while out_ch takes results.
// Stages: halve and guess, three multiplies split into front and back halves,
// 1.5 - t split into align/add and normalize/round, then NaN folding.
// A stall at out_ch freezes every stage; in_ch.ready drops at the same time.
// arst_n clears the valid bits only; no other reset sequence is needed.
module fast_inverse_sqrt_float_unit (
	input  logic clk,
	input  logic arst_n,
	fisqrt_if.sink   in_ch,
	fisqrt_if.source out_ch
);
	import fisqrt_pkg::*;

	logic [PIPE_DEPTH-1:0] vld_q;
	logic                  adv;

	f32_t     h_s1, y_s1;
	mul_raw_t p_s2; f32_t y_s2;
	f32_t     t_s3, y_s3;
	mul_raw_t p_s4; f32_t y_s4;
	f32_t     t_s5, y_s5;
	mul_raw_t d_s6; f32_t y_s6;
	f32_t     u_s7, y_s7;
	mul_raw_t p_s8;
	f32_t     r_s9;
	f32_t     r_s10;

	assign adv = !vld_q[PIPE_DEPTH-1] || out_ch.ready;
	assign in_ch.ready = adv;
	assign out_ch.valid = vld_q[PIPE_DEPTH-1];
	assign out_ch.bits = r_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], in_ch.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// halve x, form the guess
			h_s1 <= mul_back(mul_front(ONE_HALF, in_ch.bits));
			y_s1 <= MAGIC_GUESS - {in_ch.bits[31], in_ch.bits[31:1]};
			p_s2 <= mul_front(h_s1, y_s1);
			y_s2 <= y_s1;
			t_s3 <= mul_back(p_s2);
			y_s3 <= y_s2;
			p_s4 <= mul_front(t_s3, y_s3);
			y_s4 <= y_s3;
			t_s5 <= mul_back(p_s4);
			y_s5 <= y_s4;
			d_s6 <= sub_front(t_s5);
			y_s6 <= y_s5;
			u_s7 <= mul_back(d_s6);
			y_s7 <= y_s6;
			p_s8 <= mul_front(y_s7, u_s7);
			r_s9 <= mul_back(p_s8);
			r_s10 <= ((r_s9[30:23] == 8'hFF) && (r_s9[22:0] != 23'd0)) ? QNAN_BITS : r_s9;
		end
	end

endmodule

[src/fisqrt_checker.sv]
// ----------------------------------------------------------------------------
// fisqrt_checker
// Port-level checks on the inverse square root unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fisqrt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_bits
);
	import fisqrt_pkg::*;

	logic out_stall;
	logic out_is_nan;

	assign out_stall = out_valid && !out_ready;
	assign out_is_nan = (out_bits[30:23] == 8'hFF) && (out_bits[22:0] != 23'd0);

	`ASSERT_IMPL(a_ready_when_out_free, clk, arst_n, !out_valid, in_ready, "ready low while empty")
	`ASSERT_NEXT(a_out_holds, clk, arst_n, out_stall, out_valid && $stable(out_bits), "result moved")
	`ASSERT_IMPL(a_nan_canonical, clk, arst_n, out_valid && out_is_nan, out_bits == QNAN_BITS, "bad NaN")
endmodule

bind fast_inverse_sqrt_float_unit fisqrt_checker u_fisqrt_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_bits(out_ch.bits)
);

[verif/fisqrt_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisqrt_result_checker
// Watches both channels of the inverse square root unit, predicts each result
// with exact integer binary32 arithmetic and compares it with the oldest one.
// ----------------------------------------------------------------------------
module fisqrt_result_checker (
	input  logic clk,
	input  logic arst_n,
	fisqrt_if    in_mon,
	fisqrt_if    out_mon,
	output int   fail_count,
	output int   pending
);
	import fisqrt_pkg::*;

	logic [31:0] expected_results[$];

	// Round m * 2^e to binary32, nearest-even, keeping subnormals.
	function automatic logic [31:0] round_to_f32(logic s, logic [255:0] m, int e);
		int          msb;
		int          ulp;
		int          sh;
		int          be;
		logic [255:0] q;
		logic        g;
		logic        st;
		logic [31:0] r;
		if (m == '0) return {s, 31'd0};
		msb = 0;
		for (int i = 0; i < 256; i++) if (m[i]) msb = i;
		ulp = msb + e - 23;
		if (ulp < -149) ulp = -149;
		sh = ulp - e;
		if (sh <= 0) begin
			q = m << (-sh);
		end else begin
			q = m >> sh;
			g = m[sh-1];
			st = (m & ((256'd1 << (sh - 1)) - 256'd1)) != '0;
			if (g && (st || q[0])) q = q + 256'd1;
		end
		if (q[24]) begin
			q = q >> 1;
			ulp++;
		end
		if (!q[23]) begin
			r = {s, 8'd0, q[22:0]};
		end else begin
			be = ulp + 150;
			if (be >= 255) r = {s, 8'hFF, 23'd0};
			else r = {s, be[7:0], q[22:0]};
		end
		return r;
	endfunction

	function automatic logic is_nan32(logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf32(logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
	endfunction

	function automatic logic [23:0] mant32(logic [31:0] a);
		return (a[30:23] == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
	endfunction

	function automatic int exp32(logic [31:0] a);
		return (a[30:23] == 8'd0) ? -149 : int'(a[30:23]) - 150;
	endfunction

	function automatic logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
		logic s;
		logic [255:0] m;
		s = a[31] ^ b[31];
		if (is_nan32(a) || is_nan32(b)) return QNAN_BITS;
		if ((is_inf32(a) && b[30:0] == '0) || (is_inf32(b) && a[30:0] == '0))
			return QNAN_BITS;
		if (is_inf32(a) || is_inf32(b)) return {s, 8'hFF, 23'd0};
		if (a[30:0] == '0 || b[30:0] == '0) return {s, 31'd0};
		m = 256'(mant32(a)) * 256'(mant32(b));
		return round_to_f32(s, m, exp32(a) + exp32(b));
	endfunction

	// 1.5 - t, aligned exactly at the lower of the two exponents
	function automatic logic [31:0] three_halves_minus(logic [31:0] t);
		int          et;
		int          e0;
		logic [255:0] a;
		logic [255:0] b;
		if (is_nan32(t)) return QNAN_BITS;
		if (is_inf32(t)) return {~t[31], 8'hFF, 23'd0};
		if (t[30:0] == '0) return THREE_HALVES;
		et = exp32(t);
		e0 = (et < -1) ? et : -1;
		a = 256'd3 << (-1 - e0);
		b = 256'(mant32(t)) << (et - e0);
		if (t[31]) return round_to_f32(1'b0, a + b, e0);
		if (a >= b) return round_to_f32(1'b0, a - b, e0);
		return round_to_f32(1'b1, b - a, e0);
	endfunction

	function automatic logic [31:0] predict_inv_sqrt(logic [31:0] x);
		logic [31:0] guess;
		logic [31:0] h;
		logic [31:0] t;
		logic [31:0] r;
		guess = MAGIC_GUESS - {x[31], x[31:1]};
		h = mul32(ONE_HALF, x);
		t = mul32(h, guess);
		t = mul32(t, guess);
		r = mul32(guess, three_halves_minus(t));
		return is_nan32(r) ? QNAN_BITS : r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %h", $time, out_mon.bits);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (want !== out_mon.bits) begin
						$display("%0t: result_bits mismatch, expected %h actual %h",
							$time, want, out_mon.bits);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_mon.valid && in_mon.ready)
				expected_results.push_back(predict_inv_sqrt(in_mon.bits));
			pending <= expected_results.size();
		end
	end

endmodule

[verif/tb_fast_inverse_sqrt_float_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fast_inverse_sqrt_float_unit
// Drives directed and random binary32 operands through the unit with bursty
// input, random output stalls and one long hold-off; the checker scores them.
// ----------------------------------------------------------------------------
module tb_fast_inverse_sqrt_float_unit;

	localparam int NUM_RANDOM = 2000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   accepted_count;
	bit   all_sent;

	fisqrt_if in_ch();
	fisqrt_if out_ch();

	fast_inverse_sqrt_float_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	fisqrt_result_checker scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.in_mon(in_ch),
		.out_mon(out_ch),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) accepted_count <= 0;
		else if (in_ch.valid && in_ch.ready) accepted_count <= accepted_count + 1;
	end

	// Receiver: changing stall pattern, plus one long hold-off while input keeps coming
	initial begin
		int hold_left;
		int cyc;
		bit held;
		hold_left = 0;
		cyc = 0;
		held = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (!held && accepted_count >= 600) begin
				held = 1;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				case ((cyc / 64) % 4)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= ($urandom_range(1, 100) <= 50);
					2: out_ch.ready <= ($urandom_range(1, 100) <= 85);
					default: out_ch.ready <= ($urandom_range(1, 100) <= 20);
				endcase
			end
		end
	end

	function automatic logic [31:0] random_operand();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $urandom;
			4, 5, 6, 7: v = {1'b0, 8'($urandom_range(1, 254)), 23'($urandom)};
			8: v = {1'b0, 8'd0, 23'($urandom)};
			default: begin
				case ($urandom_range(0, 3))
					0: v = 32'h7F800000;
					1: v = {1'b0, 8'hFF, 23'($urandom)};
					2: v = {$urandom_range(0, 1) == 1, 31'd0};
					default: v = {1'b0, 8'($urandom_range(0, 3)), 23'($urandom)};
				endcase
			end
		endcase
		return v;
	endfunction

	initial begin
		logic [31:0] directed[$];
		logic [31:0] operand;
		int          idx;
		int          burst_left;
		int          total;
		directed = '{32'h00000000, 32'h80000000, 32'h3F800000, 32'h40800000,
			32'h7F800000, 32'hFF800000, 32'h7FC00001, 32'h7F800001, 32'h00000001,
			32'h007FFFFF, 32'h00800000, 32'h7F7FFFFF, 32'hBF800000, 32'hFFFFFFFF,
			32'h80000001, 32'h3F000000, 32'h5F3759DF, 32'h40490FDB, 32'h00400000,
			32'h7FFFFFFF, 32'h3E800000, 32'h00000002};
		total = directed.size() + NUM_RANDOM;
		all_sent = 0;
		in_ch.valid = 1'b0;
		in_ch.bits = '0;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		burst_left = 0;
		// each pass starts at a falling edge right after the previous item was taken
		for (idx = 0; idx < total; idx++) begin
			if (idx == 1200) begin
				// drain before continuing
				in_ch.valid <= 1'b0;
				while (pending != 0 || accepted_count != idx) @(negedge clk);
			end
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 30);
				if (idx > 300 && idx < 500) burst_left = 200;
				else if ($urandom_range(0, 2) != 0) begin
					in_ch.valid <= 1'b0;
					repeat ($urandom_range(1, 8)) @(negedge clk);
				end
			end
			burst_left--;
			operand = (idx < directed.size()) ? directed[idx] : random_operand();
			in_ch.valid <= 1'b1;
			in_ch.bits <= operand;
			do @(negedge clk); while (accepted_count <= idx);
		end
		in_ch.valid <= 1'b0;
		all_sent = 1;
	end

	initial begin
		wait (all_sent);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("fast_inverse_sqrt_float_unit regression: pass");
		else
			$display("fast_inverse_sqrt_float_unit regression: fail");
		$finish;
	end

	initial begin
		#5ms;
		$display("fast_inverse_sqrt_float_unit regression: fail");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/fisqrt_pkg.sv
src/fisqrt_if.sv
src/fast_inverse_sqrt_float_unit.sv
src/fisqrt_checker.sv
verif/fisqrt_result_checker.sv
verif/tb_fast_inverse_sqrt_float_unit.sv
